[rtl/acrc_pkg.sv]
// ----------------------------------------------------------------------------
// Access range race checker package
// Shared widths, result codes and the structs passed between the core and
// its per-thread cells.
// ----------------------------------------------------------------------------
package acrc_pkg;

   localparam int THREAD_SLOTS = 16;
   localparam int TID_W        = 4;
   localparam int ADDR_W       = 48;
   localparam int SIZE_W       = 21;
   localparam int END_W        = ADDR_W + 1;
   localparam int ID_W         = 32;
   localparam int KIND_W       = 2;

   localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WW   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_WR   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_RW   = 2'd3;

   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   // request as broadcast to every cell
   typedef struct packed {
      logic              valid;
      logic              clear;
      logic              check;
      logic [ADDR_W-1:0] w_addr;
      logic [END_W-1:0]  w_end;
      logic              w_ok;
      logic [ADDR_W-1:0] r_addr;
      logic [END_W-1:0]  r_end;
      logic              r_ok;
      logic [ID_W-1:0]   inst_id;
   } acrc_bcast_type;

   // first conflict found so far along the cell chain
   typedef struct packed {
      logic              found;
      logic [TID_W-1:0]  thread;
      logic [KIND_W-1:0] kind;
   } acrc_hit_type;

   function automatic logic size_ok(input logic [SIZE_W-1:0] size);
      return (size != '0) && !size[SIZE_W-1];
   endfunction

   function automatic logic [END_W-1:0] range_end(input logic [ADDR_W-1:0] addr,
                                                 input logic [SIZE_W-1:0] size);
      return {1'b0, addr} + END_W'(size);
   endfunction

   function automatic logic ranges_meet(input logic [ADDR_W-1:0] a,
                                        input logic [END_W-1:0]  a_end,
                                        input logic [ADDR_W-1:0] b,
                                        input logic [END_W-1:0]  b_end);
      return (a == b)
          || ((a <= b) && ({1'b0, b} < a_end))
          || ((b <= a) && ({1'b0, a} < b_end));
   endfunction

endpackage

[rtl/acrc_cell.sv]
// ----------------------------------------------------------------------------
// Access range race checker cell
// Holds one thread's pending entry, compares it against the broadcast
// request and merges its hit into the priority chain from its neighbor.
// ----------------------------------------------------------------------------
module acrc_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        self_check,
   input  logic                        sel,
   input  logic [acrc_pkg::TID_W-1:0]  cell_index,
   input  acrc_pkg::acrc_bcast_type    bcast,
   input  acrc_pkg::acrc_hit_type      hit_prev,
   output acrc_pkg::acrc_hit_type      hit_next
);
   import acrc_pkg::*;

   logic              w_ok_ff;
   logic              r_ok_ff;
   logic [ADDR_W-1:0] w_addr_ff;
   logic [END_W-1:0]  w_end_ff;
   logic [ADDR_W-1:0] r_addr_ff;
   logic [END_W-1:0]  r_end_ff;
   logic [ID_W-1:0]   inst_id_ff;
   logic [KIND_W-1:0] kind_ff;
   logic [KIND_W-1:0] kind_in;
   logic              counts;

   always_comb begin
      counts  = self_check || (bcast.inst_id != inst_id_ff);
      kind_in = KIND_NONE;
      if (bcast.valid && bcast.check && !sel && counts) begin
         if (bcast.w_ok && w_ok_ff
             && ranges_meet(bcast.w_addr, bcast.w_end, w_addr_ff, w_end_ff)) begin
            kind_in = KIND_WW;
         end else if (bcast.w_ok && r_ok_ff
             && ranges_meet(bcast.w_addr, bcast.w_end, r_addr_ff, r_end_ff)) begin
            kind_in = KIND_WR;
         end else if (bcast.r_ok && w_ok_ff
             && ranges_meet(bcast.r_addr, bcast.r_end, w_addr_ff, w_end_ff)) begin
            kind_in = KIND_RW;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ok_ff <= 1'b0;
         r_ok_ff <= 1'b0;
         kind_ff <= KIND_NONE;
      end else begin
         if (bcast.valid) begin
            kind_ff <= kind_in;
         end
         if (bcast.valid && sel) begin
            if (bcast.clear) begin
               w_ok_ff <= 1'b0;
               r_ok_ff <= 1'b0;
            end else begin
               w_ok_ff <= bcast.w_ok;
               r_ok_ff <= bcast.r_ok;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (bcast.valid && sel && !bcast.clear) begin
         w_addr_ff  <= bcast.w_addr;
         w_end_ff   <= bcast.w_end;
         r_addr_ff  <= bcast.r_addr;
         r_end_ff   <= bcast.r_end;
         inst_id_ff <= bcast.inst_id;
      end
   end

   always_comb begin
      hit_next = hit_prev;
      if (!hit_prev.found && (kind_ff != KIND_NONE)) begin
         hit_next.found  = 1'b1;
         hit_next.thread = cell_index;
         hit_next.kind   = kind_ff;
      end
   end

endmodule

[rtl/access_range_race_checker_core.sv]
// ----------------------------------------------------------------------------
// Access range race checker core
// Per-thread pending access table with range overlap race detection.
// ----------------------------------------------------------------------------
// A request is accepted when req_valid is high and req_stall low. It is
// registered for broadcast; every thread cell then compares its entry with
// it and stores the issuing thread's entry; then the hits ripple down the
// cell chain to pick the lowest conflicting thread into the output register
// on the rsp_ ports. No request is taken while one sits in the broadcast
// register or in a stalled compare stage; the output register lets the next
// one enter while a result waits on rsp_stall. A clear request answers all
// zero. The table is empty after reset; no warm-up is needed.
module access_range_race_checker_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic                          csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [acrc_pkg::TID_W-1:0]    req_thread_id,
   input  logic [acrc_pkg::ADDR_W-1:0]   req_write_addr,
   input  logic [acrc_pkg::SIZE_W-1:0]   req_write_size,
   input  logic [acrc_pkg::ADDR_W-1:0]   req_read_addr,
   input  logic [acrc_pkg::SIZE_W-1:0]   req_read_size,
   input  logic [acrc_pkg::ID_W-1:0]     req_inst_id,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_race_found,
   output logic [acrc_pkg::TID_W-1:0]    rsp_other_thread,
   output logic [acrc_pkg::KIND_W-1:0]   rsp_race_kind
);
   import acrc_pkg::*;

   logic              self_check_ff;
   acrc_bcast_type    bcast_ff;
   acrc_bcast_type    bcast_in;
   logic [TID_W-1:0]  tid_ff;
   logic              cmp_v_ff;
   logic              rsp_v_ff;
   acrc_hit_type      rsp_ff;
   logic              cmp_adv;
   logic              req_take;
   logic [THREAD_SLOTS-1:0] sel;
   acrc_hit_type      chain [THREAD_SLOTS+1];

   assign cmp_adv   = cmp_v_ff && (!rsp_v_ff || !rsp_stall);
   assign req_stall = bcast_ff.valid || (cmp_v_ff && !cmp_adv);
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      bcast_in.valid   = req_take;
      bcast_in.clear   = (req_type == OP_CLEAR);
      bcast_in.check   = (req_type == OP_RECORD);
      bcast_in.w_addr  = req_write_addr;
      bcast_in.w_end   = range_end(req_write_addr, req_write_size);
      bcast_in.w_ok    = size_ok(req_write_size);
      bcast_in.r_addr  = req_read_addr;
      bcast_in.r_end   = range_end(req_read_addr, req_read_size);
      bcast_in.r_ok    = size_ok(req_read_size);
      bcast_in.inst_id = req_inst_id;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         self_check_ff  <= 1'b0;
         bcast_ff.valid <= 1'b0;
         cmp_v_ff       <= 1'b0;
         rsp_v_ff       <= 1'b0;
      end else begin
         if (csr_write_en) begin
            self_check_ff <= csr_write_data;
         end
         bcast_ff.valid <= req_take;
         if (req_take) begin
            bcast_ff.clear   <= bcast_in.clear;
            bcast_ff.check   <= bcast_in.check;
            bcast_ff.w_addr  <= bcast_in.w_addr;
            bcast_ff.w_end   <= bcast_in.w_end;
            bcast_ff.w_ok    <= bcast_in.w_ok;
            bcast_ff.r_addr  <= bcast_in.r_addr;
            bcast_ff.r_end   <= bcast_in.r_end;
            bcast_ff.r_ok    <= bcast_in.r_ok;
            bcast_ff.inst_id <= bcast_in.inst_id;
         end
         if (bcast_ff.valid) begin
            cmp_v_ff <= 1'b1;
         end else if (cmp_adv) begin
            cmp_v_ff <= 1'b0;
         end
         if (cmp_adv) begin
            rsp_v_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         tid_ff <= req_thread_id;
      end
      if (cmp_adv) begin
         rsp_ff <= chain[THREAD_SLOTS];
      end
   end

   assign chain[0] = '{found: 1'b0, thread: '0, kind: KIND_NONE};

   for (genvar g = 0; g < THREAD_SLOTS; g++) begin : g_cell
      assign sel[g] = (32'(tid_ff) == 32'(g));

      acrc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .self_check (self_check_ff),
         .sel        (sel[g]),
         .cell_index (TID_W'(g)),
         .bcast      (bcast_ff),
         .hit_prev   (chain[g]),
         .hit_next   (chain[g+1])
      );
   end

   assign rsp_valid        = rsp_v_ff;
   assign rsp_race_found   = rsp_ff.found;
   assign rsp_other_thread = rsp_ff.thread;
   assign rsp_race_kind    = rsp_ff.kind;

   a_cmp_after_bcast: assert property (@(posedge clock) disable iff (reset)
      bcast_ff.valid |=> cmp_v_ff)
      else $error("compare stage did not pick up request");

   a_single_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(bcast_ff.valid && cmp_v_ff))
      else $error("two requests in flight before the output register");

   a_clear_no_hit: assert property (@(posedge clock) disable iff (reset)
      bcast_ff.valid && !bcast_ff.check |=> !chain[THREAD_SLOTS].found)
      else $error("clear request produced a race hit");

   a_none_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_race_found |-> (rsp_race_kind == KIND_NONE)
                                       && (rsp_other_thread == '0))
      else $error("no race reported with nonzero thread or kind");

endmodule
